### rtl/vdt_pkg.sv
// Shared types and sizing for the vertex deduplication table.
// No dependencies; imported by every module under rtl/.
package vdt_pkg;

    localparam int MAX_VERTICES = 4096;
    localparam int ADDR_W       = $clog2(MAX_VERTICES);
    localparam int COUNT_W      = $clog2(MAX_VERTICES + 1);
    localparam int COORD_W      = 32;
    localparam int IDX_W        = 12;

    localparam logic ACT_CLEAR  = 1'b0;
    localparam logic ACT_VERTEX = 1'b1;

    typedef struct packed {
        logic               action;
        logic [COORD_W-1:0] coord_x;
        logic [COORD_W-1:0] coord_y;
        logic [COORD_W-1:0] coord_z;
    } in_t;

    typedef struct packed {
        logic [IDX_W-1:0] vertex_index;
        logic             is_new;
        logic             table_full;
    } out_t;

    // controller -> datapath
    typedef struct packed {
        logic load;    // latch accepted transaction, restart scan
        logic clear;   // empty the table
        logic scan;    // issue next table read
        logic finish;  // settle result, append if needed
        logic emit;    // move settled result to output register
    } ctl_t;

    // datapath -> controller
    typedef struct packed {
        logic done;      // scan has a hit or has run out of entries
        logic res_busy;  // output register holds an untaken result
    } sts_t;

endpackage

### rtl/vertex_dedup_table.sv
// Top level of the vertex deduplication table.
// Depends on vdt_pkg, vdt_ctrl and vdt_datapath.
// Usage:
//   cmd channel (cmd_valid/cmd_ready, payload cmd of in_t) carries one
//   command per transaction. action = clear empties the table and gives
//   no result; action = vertex looks the three coordinate bit patterns up.
//   res channel (res_valid/res_ready, payload res of out_t) returns one
//   transaction per vertex command: index of the first stored match in
//   insertion order, or the index it was appended at (is_new), or
//   table_full with index 0 when nothing matched and no entry was free.
//   Matching is float equality: +0 == -0, a NaN never matches.
// Scan and handshake:
//   one stored entry compared per cycle; cmd_ready rises together with
//   res_valid. One command is scanned at a time.
// Reset: rst_n (async, low) empties the table; store contents are not
//   cleared and are never read before being written.
// Stall: a finished result sits in the output register; the next command
//   is accepted and scanned meanwhile, and only its hand-over waits.
module vertex_dedup_table
    import vdt_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic cmd_valid,
    output logic cmd_ready,
    input  in_t  cmd,
    output logic res_valid,
    input  logic res_ready,
    output out_t res
);

    ctl_t ctl;
    sts_t sts;

    vdt_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_valid  (cmd_valid),
        .cmd_action (cmd.action),
        .cmd_ready  (cmd_ready),
        .res_ready  (res_ready),
        .sts        (sts),
        .ctl        (ctl)
    );

    vdt_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .ctl       (ctl),
        .sts       (sts),
        .res_ready (res_ready),
        .res_valid (res_valid),
        .res       (res)
    );

endmodule

### rtl/vdt_ctrl.sv
// Sequencing FSM for the vertex deduplication table.
// Depends on vdt_pkg; drives vdt_datapath through ctl_t / sts_t.
module vdt_ctrl
    import vdt_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic cmd_valid,
    input  logic cmd_action,
    output logic cmd_ready,
    input  logic res_ready,
    input  sts_t sts,
    output ctl_t ctl
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_HOLD
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   accept;

    assign cmd_ready = (state_reg == S_IDLE);
    assign accept    = cmd_valid && cmd_ready;

    always_comb
    begin
        state_next = state_reg;
        ctl        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (cmd_action == ACT_CLEAR)
                    begin
                        ctl.clear = 1'b1;
                    end
                    else
                    begin
                        ctl.load   = 1'b1;
                        state_next = S_SCAN;
                    end
                end
            end
            S_SCAN:
            begin
                if (sts.done)
                begin
                    ctl.finish = 1'b1;
                    state_next = S_HOLD;
                end
                else
                begin
                    ctl.scan = 1'b1;
                end
            end
            S_HOLD:
            begin
                if (!sts.res_busy || res_ready)
                begin
                    ctl.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

### rtl/vdt_datapath.sv
// Vertex store, scan pointer, float-equality compare and output register.
// Depends on vdt_pkg; commanded by vdt_ctrl.
module vdt_datapath
    import vdt_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  in_t  cmd,
    input  ctl_t ctl,
    output sts_t sts,
    input  logic res_ready,
    output logic res_valid,
    output out_t res
);

    localparam int ENTRY_W = 3 * COORD_W;
    localparam logic [COORD_W-2:0] EXP_ALL_ONES = {8'hFF, {(COORD_W - 9){1'b0}}};

    // IEEE single equality on raw bits: NaN never equal, +0 == -0
    function automatic logic coord_equal(input logic [COORD_W-1:0] a,
                                         input logic [COORD_W-1:0] b);
        logic a_nan;
        logic b_nan;
        logic zeros;
        a_nan = (a[COORD_W-2:0] > EXP_ALL_ONES);
        b_nan = (b[COORD_W-2:0] > EXP_ALL_ONES);
        zeros = (a[COORD_W-2:0] == '0) && (b[COORD_W-2:0] == '0);
        return !a_nan && !b_nan && (zeros || (a == b));
    endfunction

    logic [ENTRY_W-1:0] mem [MAX_VERTICES];

    logic [ENTRY_W-1:0] key_reg;
    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] scan_addr_reg;
    logic [ENTRY_W-1:0] rd_data_reg;
    logic [COUNT_W-1:0] rd_idx_reg;
    logic               rd_vld_reg;
    out_t               pend_reg;
    out_t               res_reg;
    logic               res_valid_reg;

    logic issue;
    logic hit;
    logic full;
    out_t pend_next;

    assign issue = ctl.scan && (scan_addr_reg < count_reg);
    assign hit   = rd_vld_reg
                 && coord_equal(rd_data_reg[3*COORD_W-1:2*COORD_W], key_reg[3*COORD_W-1:2*COORD_W])
                 && coord_equal(rd_data_reg[2*COORD_W-1:COORD_W], key_reg[2*COORD_W-1:COORD_W])
                 && coord_equal(rd_data_reg[COORD_W-1:0], key_reg[COORD_W-1:0]);
    assign full  = (count_reg == COUNT_W'(MAX_VERTICES));

    assign sts.done     = hit || (!rd_vld_reg && (scan_addr_reg >= count_reg));
    assign sts.res_busy = res_valid_reg;

    always_comb
    begin
        pend_next = pend_reg;
        if (ctl.finish)
        begin
            if (hit)
            begin
                pend_next.vertex_index = IDX_W'(rd_idx_reg);
                pend_next.is_new       = 1'b0;
                pend_next.table_full   = 1'b0;
            end
            else if (full)
            begin
                pend_next.vertex_index = '0;
                pend_next.is_new       = 1'b0;
                pend_next.table_full   = 1'b1;
            end
            else
            begin
                pend_next.vertex_index = IDX_W'(count_reg);
                pend_next.is_new       = 1'b1;
                pend_next.table_full   = 1'b0;
            end
        end
    end

    // store: one write port (append), one registered read port (scan)
    always_ff @(posedge clk)
    begin
        if (ctl.finish && !hit && !full)
        begin
            mem[count_reg[ADDR_W-1:0]] <= key_reg;
        end
        rd_data_reg <= mem[scan_addr_reg[ADDR_W-1:0]];
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            key_reg <= {cmd.coord_x, cmd.coord_y, cmd.coord_z};
        end
        rd_idx_reg <= scan_addr_reg;
        pend_reg   <= pend_next;
        if (ctl.emit)
        begin
            res_reg <= pend_reg;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            scan_addr_reg <= '0;
            rd_vld_reg    <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (ctl.clear)
            begin
                count_reg <= '0;
            end
            else if (ctl.finish && !hit && !full)
            begin
                count_reg <= count_reg + 1'b1;
            end

            if (ctl.load)
            begin
                scan_addr_reg <= '0;
            end
            else if (issue)
            begin
                scan_addr_reg <= scan_addr_reg + 1'b1;
            end

            rd_vld_reg <= issue;

            if (ctl.emit)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (res_ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

### verif/vertex_dedup_table_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for vertex_dedup_table: random and directed commands with a
// cycle-free predictor of the lookup/append table. Depends on vdt_pkg and the block's RTL.
module vertex_dedup_table_tb;
    import vdt_pkg::*;

    // Longest quiet spell of a correct run is one full scan plus a receiver stall;
    // the limit takes that several times over.
    localparam int WATCHDOG_LIMIT   = 5 * MAX_VERTICES;
    localparam int DRAIN_CYCLES     = MAX_VERTICES + 8;
    localparam int RANDOM_PER_PHASE = 40;

    // Single-precision patterns of interest
    localparam logic [31:0] POS_ZERO   = 32'h0000_0000;
    localparam logic [31:0] NEG_ZERO   = 32'h8000_0000;
    localparam logic [31:0] QUIET_NAN  = 32'h7FC0_0000;
    localparam logic [31:0] SIG_NAN    = 32'h7F80_0001;
    localparam logic [31:0] ALL_ONES   = 32'hFFFF_FFFF;
    localparam logic [31:0] POS_INF    = 32'h7F80_0000;
    localparam logic [31:0] NEG_INF    = 32'hFF80_0000;
    localparam logic [31:0] ONE        = 32'h3F80_0000;
    localparam logic [31:0] MAX_NORMAL = 32'h7F7F_FFFF;
    localparam logic [31:0] MIN_DENORM = 32'h0000_0001;
    localparam logic [31:0] MAG_MASK   = 32'h7FFF_FFFF;

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic cmd_valid = 1'b0;
    in_t  cmd       = '0;
    logic res_ready = 1'b0;
    logic cmd_ready;
    logic res_valid;
    out_t res;

    vertex_dedup_table DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    initial forever #5 clk = ~clk;

    // ------------------------------------------------------------------
    // Predictor state: own copy of the vertex store and its fill level.
    // Only entries below known_vertices are ever looked at.
    // ------------------------------------------------------------------
    logic [31:0] known_x [MAX_VERTICES];
    logic [31:0] known_y [MAX_VERTICES];
    logic [31:0] known_z [MAX_VERTICES];
    int unsigned known_vertices = 0;

    in_t  command_backlog [$];   // commands waiting to be driven
    out_t lookup_answers  [$];   // predicted results, oldest first
    in_t  recent_vertices [$];   // vertices sent lately, reused to provoke hits

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int error_count   = 0;
    int clears_taken  = 0;
    int vertices_sent = 0;
    int appends_seen  = 0;
    int hits_seen     = 0;
    int full_seen     = 0;
    int quiet_cycles  = 0;

    // C float equality on raw bits: NaN never equal, +0 == -0
    function automatic bit float_eq(logic [31:0] a, logic [31:0] b);
        if ((a & MAG_MASK) > POS_INF || (b & MAG_MASK) > POS_INF)
            return 1'b0;
        if ((a & MAG_MASK) == 0 && (b & MAG_MASK) == 0)
            return 1'b1;
        return a == b;
    endfunction

    // Works out the answer to one accepted command and updates the table copy.
    function automatic void resolve_vertex(in_t c);
        out_t        r;
        bit          hit;
        int unsigned i;
        if (c.action == ACT_CLEAR)
        begin
            known_vertices = 0;
            clears_taken++;
            return;
        end
        vertices_sent++;
        r   = '0;
        hit = 1'b0;
        for (i = 0; i < known_vertices && !hit; i++)
        begin
            if (float_eq(known_x[i], c.coord_x) && float_eq(known_y[i], c.coord_y) &&
                float_eq(known_z[i], c.coord_z))
            begin
                hit            = 1'b1;
                r.vertex_index = IDX_W'(i);
            end
        end
        if (!hit)
        begin
            if (known_vertices >= MAX_VERTICES)
                r.table_full = 1'b1;
            else
            begin
                known_x[known_vertices] = c.coord_x;
                known_y[known_vertices] = c.coord_y;
                known_z[known_vertices] = c.coord_z;
                r.vertex_index = IDX_W'(known_vertices);
                r.is_new       = 1'b1;
                known_vertices++;
            end
        end
        lookup_answers.insert(lookup_answers.size(), r);
    endfunction

    function automatic in_t make_command(logic act, logic [31:0] x, logic [31:0] y,
                                         logic [31:0] z);
        in_t c;
        c.action  = act;
        c.coord_x = x;
        c.coord_y = y;
        c.coord_z = z;
        return c;
    endfunction

    // Appends one command to the tail of the backlog
    function automatic void enqueue_command(in_t c);
        command_backlog.insert(command_backlog.size(), c);
    endfunction

    // Mostly awkward float patterns, otherwise any 32-bit word
    function automatic logic [31:0] random_coord();
        case ($urandom_range(15))
            0: return POS_ZERO;
            1: return NEG_ZERO;
            2: return QUIET_NAN;
            3: return SIG_NAN;
            4: return ALL_ONES;
            5: return POS_INF;
            6: return NEG_INF;
            7: return ONE;
            8: return MAX_NORMAL;
            9: return MIN_DENORM;
            default: return $urandom();
        endcase
    endfunction

    function automatic in_t random_command();
        in_t c;
        int  pick;
        pick = $urandom_range(99);
        c = make_command(ACT_VERTEX, $urandom(), $urandom(), $urandom());
        if (pick < 6)
            c.action = ACT_CLEAR;
        else if (pick < 55 && recent_vertices.size() > 0)
        begin
            // repeat a recent vertex; sometimes flip the sign of its zeros
            c = recent_vertices[$urandom_range(recent_vertices.size() - 1)];
            if ($urandom_range(2) == 0)
            begin
                if ((c.coord_x & MAG_MASK) == 0) c.coord_x[31] = ~c.coord_x[31];
                if ((c.coord_y & MAG_MASK) == 0) c.coord_y[31] = ~c.coord_y[31];
                if ((c.coord_z & MAG_MASK) == 0) c.coord_z[31] = ~c.coord_z[31];
            end
        end
        else if (pick < 85)
            c = make_command(ACT_VERTEX, random_coord(), random_coord(), random_coord());
        if (c.action == ACT_VERTEX)
        begin
            recent_vertices.insert(recent_vertices.size(), c);
            if (recent_vertices.size() > 24)
                void'(recent_vertices.pop_front());
        end
        return c;
    endfunction

    // ------------------------------------------------------------------
    // Driver: presents backlog commands, predicts each accepted transaction.
    // cmd_valid gets at most one assignment per edge.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cmd_valid && cmd_ready)
                resolve_vertex(cmd);
            if (!cmd_valid || cmd_ready)
            begin
                if (command_backlog.size() > 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    cmd       <= command_backlog.pop_front();
                    cmd_valid <= 1'b1;
                end
                else
                    cmd_valid <= 1'b0;
            end
        end
    end

    function automatic void check_field(string name, int unsigned want, int unsigned got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            error_count++;
        end
    endfunction

    // ------------------------------------------------------------------
    // Monitor: random back-pressure, compares each result transaction
    // against the oldest prediction.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        out_t want;
        if (rst_n)
        begin
            if (res_valid && res_ready)
            begin
                if (lookup_answers.size() == 0)
                begin
                    $error("unexpected result: index %0d new %0b full %0b",
                           res.vertex_index, res.is_new, res.table_full);
                    error_count++;
                end
                else
                begin
                    want = lookup_answers.pop_front();
                    check_field("vertex_index", want.vertex_index, res.vertex_index);
                    check_field("is_new", want.is_new, res.is_new);
                    check_field("table_full", want.table_full, res.table_full);
                    if (want.table_full)
                        full_seen++;
                    else if (want.is_new)
                        appends_seen++;
                    else
                        hits_seen++;
                end
            end
            res_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Watchdog: any accepted transaction on either channel restarts the count
    always @(posedge clk)
    begin
        if (!rst_n || (cmd_valid && cmd_ready) || (res_valid && res_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Watchdog: no transaction for %0d cycles", quiet_cycles);
            $display("Test completed with failures");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // Sender holds off until the backlog is out and every result is back.
    // Sampled on the falling edge so the driver's updates have settled.
    task automatic drain();
        @(negedge clk);
        while (command_backlog.size() != 0 || cmd_valid || lookup_answers.size() != 0)
            @(negedge clk);
    endtask

    task automatic run_random(int s_pct, int r_pct);
        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
        repeat (RANDOM_PER_PHASE)
            enqueue_command(random_command());
        drain();
    endtask

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        send_idle_pct = 14;
        recv_idle_pct = 53;

        // Directed: signed zeros, NaNs that never match, infinities, extremes,
        // clears with odd payloads and back to back
        enqueue_command(make_command(ACT_VERTEX, POS_ZERO, POS_ZERO, POS_ZERO));
        enqueue_command(make_command(ACT_VERTEX, NEG_ZERO, NEG_ZERO, NEG_ZERO));
        enqueue_command(make_command(ACT_VERTEX, POS_ZERO, NEG_ZERO, POS_ZERO));
        enqueue_command(make_command(ACT_VERTEX, QUIET_NAN, ONE, ONE));
        enqueue_command(make_command(ACT_VERTEX, QUIET_NAN, ONE, ONE));
        enqueue_command(make_command(ACT_VERTEX, ONE, ONE, ALL_ONES));
        enqueue_command(make_command(ACT_VERTEX, POS_INF, NEG_INF, MAX_NORMAL));
        enqueue_command(make_command(ACT_VERTEX, POS_INF, NEG_INF, MAX_NORMAL));
        enqueue_command(make_command(ACT_VERTEX, ALL_ONES, ALL_ONES, ALL_ONES));
        enqueue_command(make_command(ACT_VERTEX, SIG_NAN, MIN_DENORM, 32'h8000_0001));
        enqueue_command(make_command(ACT_VERTEX, ONE, ONE, ONE));
        enqueue_command(make_command(ACT_VERTEX, ONE, ONE, 32'h3F80_0001));
        enqueue_command(make_command(ACT_VERTEX, ONE, ONE, ONE));
        enqueue_command(make_command(ACT_CLEAR, ALL_ONES, ALL_ONES, ALL_ONES));
        enqueue_command(make_command(ACT_VERTEX, ONE, ONE, ONE));
        enqueue_command(make_command(ACT_CLEAR, POS_ZERO, POS_ZERO, POS_ZERO));
        enqueue_command(make_command(ACT_CLEAR, ONE, ONE, ONE));
        enqueue_command(make_command(ACT_VERTEX, NEG_ZERO, POS_ZERO, POS_ZERO));
        enqueue_command(make_command(ACT_VERTEX, POS_ZERO, POS_ZERO, POS_ZERO));
        enqueue_command(make_command(ACT_VERTEX, MAG_MASK, MAG_MASK, MAG_MASK));
        enqueue_command(make_command(ACT_VERTEX, NEG_INF, POS_INF, 32'hFF7F_FFFF));

        run_random(14, 53);
        run_random(53, 14);
        run_random(0, 0);

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (lookup_answers.size() != 0)
        begin
            $error("%0d predicted results never arrived", lookup_answers.size());
            error_count++;
        end

        $display("Ran %0d vertex lookups and %0d clears under mixed back-pressure",
                 vertices_sent, clears_taken);
        $display("Results: %0d appends, %0d hits, %0d table-full; %0d errors",
                 appends_seen, hits_seen, full_seen, error_count);
        if (error_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
